[design/snav_pkg.sv]
package snav_pkg;

    // Fixed field widths.
    localparam int COORD_WIDTH = 32;
    localparam int NUM_AXES = 3;
    localparam int MASK_WIDTH = 16;
    localparam logic [MASK_WIDTH-1:0] MASK_RESET = 16'd7666;
    localparam int THRESH_FRAC_BITS_DEFAULT = 16;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_TDATA_WIDTH = ((2 * NUM_AXES * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH = 8;
    localparam int OUT_VISIBLE_BIT = 0;
    localparam int OUT_DEGENERATE_BIT = 1;

    // Arithmetic widths.  A difference of two coordinates needs one more bit, the squared
    // lengths and the dot product fit in twice that as magnitudes, and the wide products
    // are built from half-width partial products.
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int SQ_WIDTH = 2 * DIFF_WIDTH;
    localparam int SUM_WIDTH = SQ_WIDTH + 1;
    localparam int MAG_WIDTH = 2 * DIFF_WIDTH;
    localparam int HALF_WIDTH = MAG_WIDTH / 2;
    localparam int PART_WIDTH = 2 * HALF_WIDTH;
    localparam int PROD_WIDTH = 2 * MAG_WIDTH;
    localparam int NUM_CHUNKS = (PROD_WIDTH + HALF_WIDTH - 1) / HALF_WIDTH;
    localparam int CHUNK_PROD_WIDTH = HALF_WIDTH + MASK_WIDTH;
    localparam int RHS_WIDTH = PROD_WIDTH + MASK_WIDTH;

    // Pipeline stages, in order from the input.
    localparam int ST_DIFF = 0;
    localparam int ST_SQUARE = 1;
    localparam int ST_SUM = 2;
    localparam int ST_MAG = 3;
    localparam int ST_PART = 4;
    localparam int ST_WIDE = 5;
    localparam int ST_SCALE = 6;
    localparam int ST_ALIGN = 7;
    localparam int ST_CMP = 8;
    localparam int ST_RESULT = 9;
    localparam int NUM_STAGES = 10;

    typedef struct packed {
        logic [MASK_WIDTH-1:0] mask_cos_sq;
        logic [NUM_STAGES-1:0] load;
    } snav_ctrl_t;

    typedef struct packed {
        logic visible;
        logic degenerate;
    } snav_result_t;

endpackage

[design/snav_datapath.sv]
module snav_datapath #(
    parameter int THRESH_FRAC_BITS = snav_pkg::THRESH_FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic [snav_pkg::IN_TDATA_WIDTH-1:0] in_data,
    input  snav_pkg::snav_ctrl_t                ctrl,
    output snav_pkg::snav_result_t              result
);
    import snav_pkg::*;

    localparam int LHS_WIDTH = PROD_WIDTH + THRESH_FRAC_BITS;
    localparam int CMP_WIDTH = (LHS_WIDTH > RHS_WIDTH) ? LHS_WIDTH : RHS_WIDTH;
    localparam int CMP_LO = CMP_WIDTH / 2;
    localparam int CMP_HI = CMP_WIDTH - CMP_LO;
    localparam int PAD_WIDTH = NUM_CHUNKS * HALF_WIDTH;

    // Stage registers.
    logic signed [DIFF_WIDTH-1:0] a_reg [NUM_AXES];
    logic signed [DIFF_WIDTH-1:0] b_reg [NUM_AXES];
    logic signed [SQ_WIDTH-1:0]   aa_reg [NUM_AXES];
    logic signed [SQ_WIDTH-1:0]   bb_reg [NUM_AXES];
    logic signed [SQ_WIDTH-1:0]   ab_reg [NUM_AXES];
    logic signed [SUM_WIDTH-1:0]  la_sum_reg;
    logic signed [SUM_WIDTH-1:0]  lb_sum_reg;
    logic signed [SUM_WIDTH-1:0]  dot_reg;
    logic [MAG_WIDTH-1:0]         la_reg;
    logic [MAG_WIDTH-1:0]         lb_reg;
    logic [MAG_WIDTH-1:0]         dmag_reg;
    logic                         reject3_reg;
    logic                         degen3_reg;
    logic [PART_WIDTH-1:0]        dhh_reg;
    logic [PART_WIDTH-1:0]        dhl_reg;
    logic [PART_WIDTH-1:0]        dll_reg;
    logic [PART_WIDTH-1:0]        phh_reg;
    logic [PART_WIDTH-1:0]        phl_reg;
    logic [PART_WIDTH-1:0]        plh_reg;
    logic [PART_WIDTH-1:0]        pll_reg;
    logic                         reject4_reg;
    logic                         degen4_reg;
    logic [PROD_WIDTH-1:0]        dsq5_reg;
    logic [PROD_WIDTH-1:0]        prod_reg;
    logic                         reject5_reg;
    logic                         degen5_reg;
    logic [CHUNK_PROD_WIDTH-1:0]  cm_reg [NUM_CHUNKS];
    logic [PROD_WIDTH-1:0]        dsq6_reg;
    logic                         reject6_reg;
    logic                         degen6_reg;
    logic [CMP_WIDTH-1:0]         lhs_reg;
    logic [CMP_WIDTH-1:0]         rhs_reg;
    logic                         reject7_reg;
    logic                         degen7_reg;
    logic                         hi_gt_reg;
    logic                         hi_eq_reg;
    logic                         lo_ge_reg;
    logic                         reject8_reg;
    logic                         degen8_reg;
    snav_result_t                 result_reg;

    // Next values.
    logic signed [DIFF_WIDTH-1:0] a_next [NUM_AXES];
    logic signed [DIFF_WIDTH-1:0] b_next [NUM_AXES];
    logic signed [SUM_WIDTH-1:0]  la_sum_next;
    logic signed [SUM_WIDTH-1:0]  lb_sum_next;
    logic signed [SUM_WIDTH-1:0]  dot_next;
    logic signed [SUM_WIDTH-1:0]  dot_abs;
    logic [HALF_WIDTH-1:0]        dh;
    logic [HALF_WIDTH-1:0]        dl;
    logic [HALF_WIDTH-1:0]        lah;
    logic [HALF_WIDTH-1:0]        lal;
    logic [HALF_WIDTH-1:0]        lbh;
    logic [HALF_WIDTH-1:0]        lbl;
    logic [PROD_WIDTH-1:0]        dsq_next;
    logic [PROD_WIDTH-1:0]        prod_next;
    logic [PAD_WIDTH-1:0]         prod_pad;
    logic [CMP_WIDTH-1:0]         rhs_next;
    logic [CMP_WIDTH-1:0]         lhs_next;

    // Difference vectors: A points to the Earth centre, B to the ground point.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            a_next[i] = -DIFF_WIDTH'($signed(in_data[i*COORD_WIDTH +: COORD_WIDTH]));
            b_next[i] = DIFF_WIDTH'($signed(in_data[(NUM_AXES+i)*COORD_WIDTH +: COORD_WIDTH]))
                      - DIFF_WIDTH'($signed(in_data[i*COORD_WIDTH +: COORD_WIDTH]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_DIFF])
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    // Per-axis signed products.
    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_SQUARE])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                aa_reg[i] <= SQ_WIDTH'(a_reg[i]) * SQ_WIDTH'(a_reg[i]);
                bb_reg[i] <= SQ_WIDTH'(b_reg[i]) * SQ_WIDTH'(b_reg[i]);
                ab_reg[i] <= SQ_WIDTH'(a_reg[i]) * SQ_WIDTH'(b_reg[i]);
            end
        end
    end

    // Squared lengths and dot product.
    always_comb
    begin
        la_sum_next = '0;
        lb_sum_next = '0;
        dot_next = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            la_sum_next = la_sum_next + SUM_WIDTH'(aa_reg[i]);
            lb_sum_next = lb_sum_next + SUM_WIDTH'(bb_reg[i]);
            dot_next = dot_next + SUM_WIDTH'(ab_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_SUM])
        begin
            la_sum_reg <= la_sum_next;
            lb_sum_reg <= lb_sum_next;
            dot_reg <= dot_next;
        end
    end

    // Magnitude of the dot product; a negative dot product or a zero vector rejects.
    always_comb
    begin
        dot_abs = dot_reg[SUM_WIDTH-1] ? -dot_reg : dot_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_MAG])
        begin
            la_reg <= la_sum_reg[MAG_WIDTH-1:0];
            lb_reg <= lb_sum_reg[MAG_WIDTH-1:0];
            dmag_reg <= dot_abs[MAG_WIDTH-1:0];
            degen3_reg <= (la_sum_reg == '0) || (lb_sum_reg == '0);
            reject3_reg <= dot_reg[SUM_WIDTH-1] || (la_sum_reg == '0) || (lb_sum_reg == '0);
        end
    end

    // Half-width partial products of the squared dot and of the length product.
    always_comb
    begin
        dh = dmag_reg[MAG_WIDTH-1:HALF_WIDTH];
        dl = dmag_reg[HALF_WIDTH-1:0];
        lah = la_reg[MAG_WIDTH-1:HALF_WIDTH];
        lal = la_reg[HALF_WIDTH-1:0];
        lbh = lb_reg[MAG_WIDTH-1:HALF_WIDTH];
        lbl = lb_reg[HALF_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_PART])
        begin
            dhh_reg <= PART_WIDTH'(dh) * PART_WIDTH'(dh);
            dhl_reg <= PART_WIDTH'(dh) * PART_WIDTH'(dl);
            dll_reg <= PART_WIDTH'(dl) * PART_WIDTH'(dl);
            phh_reg <= PART_WIDTH'(lah) * PART_WIDTH'(lbh);
            phl_reg <= PART_WIDTH'(lah) * PART_WIDTH'(lbl);
            plh_reg <= PART_WIDTH'(lal) * PART_WIDTH'(lbh);
            pll_reg <= PART_WIDTH'(lal) * PART_WIDTH'(lbl);
            reject4_reg <= reject3_reg;
            degen4_reg <= degen3_reg;
        end
    end

    // Reassemble the full-width products.
    always_comb
    begin
        dsq_next = (PROD_WIDTH'(dhh_reg) << (2 * HALF_WIDTH))
                 + (PROD_WIDTH'(dhl_reg) << (HALF_WIDTH + 1))
                 + PROD_WIDTH'(dll_reg);
        prod_next = (PROD_WIDTH'(phh_reg) << (2 * HALF_WIDTH))
                  + (PROD_WIDTH'(phl_reg) << HALF_WIDTH)
                  + (PROD_WIDTH'(plh_reg) << HALF_WIDTH)
                  + PROD_WIDTH'(pll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_WIDE])
        begin
            dsq5_reg <= dsq_next;
            prod_reg <= prod_next;
            reject5_reg <= reject4_reg;
            degen5_reg <= degen4_reg;
        end
    end

    // Scale the length product by the threshold, one chunk per multiplier.
    always_comb
    begin
        prod_pad = PAD_WIDTH'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_SCALE])
        begin
            for (int k = 0; k < NUM_CHUNKS; k++)
            begin
                cm_reg[k] <= CHUNK_PROD_WIDTH'(prod_pad[k*HALF_WIDTH +: HALF_WIDTH])
                           * CHUNK_PROD_WIDTH'(ctrl.mask_cos_sq);
            end
            dsq6_reg <= dsq5_reg;
            reject6_reg <= reject5_reg;
            degen6_reg <= degen5_reg;
        end
    end

    // Sum the scaled chunks and align the squared dot product to the fraction.
    always_comb
    begin
        rhs_next = '0;
        for (int k = 0; k < NUM_CHUNKS; k++)
        begin
            rhs_next = rhs_next + (CMP_WIDTH'(cm_reg[k]) << (k * HALF_WIDTH));
        end
        lhs_next = CMP_WIDTH'(dsq6_reg) << THRESH_FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_ALIGN])
        begin
            lhs_reg <= lhs_next;
            rhs_reg <= rhs_next;
            reject7_reg <= reject6_reg;
            degen7_reg <= degen6_reg;
        end
    end

    // Compare in two halves.
    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_CMP])
        begin
            hi_gt_reg <= lhs_reg[CMP_WIDTH-1 -: CMP_HI] > rhs_reg[CMP_WIDTH-1 -: CMP_HI];
            hi_eq_reg <= lhs_reg[CMP_WIDTH-1 -: CMP_HI] == rhs_reg[CMP_WIDTH-1 -: CMP_HI];
            lo_ge_reg <= lhs_reg[CMP_LO-1:0] >= rhs_reg[CMP_LO-1:0];
            reject8_reg <= reject7_reg;
            degen8_reg <= degen7_reg;
        end
    end

    // Result register, which also serves as the output register.
    always_ff @(posedge clk)
    begin
        if (ctrl.load[ST_RESULT])
        begin
            result_reg.visible <= !reject8_reg && (hi_gt_reg || (hi_eq_reg && lo_ge_reg));
            result_reg.degenerate <= degen8_reg;
        end
    end

    assign result = result_reg;

endmodule

[design/satellite_nadir_angle_visibility.sv]
// Ten register stages lie between a request and its result; the last is the output register.
// Throughput: one request per cycle, sustained while the output is not stalled; each
// stage holds one rank of multiplies of at most 33 by 33 bits, a short sum of wide terms,
// or a half-width compare.
// A stalled output holds its result while empty stages further up keep accepting.
// Reset clears the stage valid bits and loads mask_cos_sq with 7666 (70 degrees).
module satellite_nadir_angle_visibility #(
    parameter int THRESH_FRAC_BITS = snav_pkg::THRESH_FRAC_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // sat_x, sat_y, sat_z, point_x, point_y, point_z, from the lowest bit up
    input  logic [snav_pkg::IN_TDATA_WIDTH-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // visible, degenerate, from the lowest bit up, then zero padding
    output logic [snav_pkg::OUT_TDATA_WIDTH-1:0] m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [snav_pkg::MASK_WIDTH-1:0]      cfg_data
);
    import snav_pkg::*;

    logic [MASK_WIDTH-1:0] mask_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;
    snav_ctrl_t            ctrl;
    snav_result_t          result;

    // Threshold register; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET;
        end
        else if (cfg_valid)
        begin
            mask_reg <= cfg_data;
        end
    end

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load[0])
        begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (load[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.mask_cos_sq = mask_reg;
    assign ctrl.load = load;

    snav_datapath #(
        .THRESH_FRAC_BITS(THRESH_FRAC_BITS)
    ) u_datapath (
        .clk    (clk),
        .in_data(s_tdata),
        .ctrl   (ctrl),
        .result (result)
    );

    // Stream outputs.
    assign s_tready = load[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    always_comb
    begin
        m_tdata = '0;
        m_tdata[OUT_VISIBLE_BIT] = result.visible;
        m_tdata[OUT_DEGENERATE_BIT] = result.degenerate;
    end

`ifndef SYNTHESIS
    // Items in flight change only by requests accepted and results taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) == $past($countones(valid_reg))
                  + $past(int'(s_tvalid && s_tready)) - $past(int'(m_tvalid && m_tready))))
        else $error("pipeline occupancy does not match accepted and delivered items");

    // A full pipeline behind a stalled output takes no new request.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !m_tready) |-> !s_tready)
        else $error("request accepted while every stage is occupied and stalled");

    // A degenerate geometry is never reported visible.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[OUT_DEGENERATE_BIT]) |-> !m_tdata[OUT_VISIBLE_BIT])
        else $error("degenerate result marked visible");

    // A configuration write lands in the threshold register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (mask_reg == $past(cfg_data)))
        else $error("threshold write lost");
`endif

endmodule

[tb/satellite_nadir_angle_visibility_tb.sv]
module satellite_nadir_angle_visibility_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import snav_pkg::*;

    localparam int PIPE_LATENCY = 10;
    localparam int FRAC_BITS = THRESH_FRAC_BITS_DEFAULT;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_GUARD = 100000;

    localparam logic signed [COORD_WIDTH-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = 32'sh8000_0000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [IN_TDATA_WIDTH-1:0]  s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0] m_tdata;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [MASK_WIDTH-1:0]      cfg_data = '0;

    // Requests waiting to be offered, and the verdicts expected back in order.
    logic [IN_TDATA_WIDTH-1:0] coord_requests[$];
    snav_result_t              visibility_expected[$];

    logic [MASK_WIDTH-1:0] mask_cos_sq_copy = MASK_RESET;
    logic                  sender_gaps_on = 1'b1;
    logic                  receiver_gaps_on = 1'b1;
    int                    send_gap = 0;
    int                    recv_stall = 0;
    int                    hold_requests = 0;
    int                    hold_served = 0;
    int                    mismatch_count = 0;
    snav_result_t          oldest_verdict;

    satellite_nadir_angle_visibility u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Exact off-nadir test: A = -S, B = P - S, visible when the dot product is
    // non-negative and its square, scaled by the fraction bits, reaches the
    // threshold times both squared lengths.
    function automatic snav_result_t predict_visibility(
        input logic [IN_TDATA_WIDTH-1:0] item,
        input logic [MASK_WIDTH-1:0]     mask
    );
        logic signed [79:0] s, p, a, b, len_a, len_b, dot;
        logic [255:0]       dot_u, len_a_u, len_b_u, mask_u, lhs, rhs;
        snav_result_t       verdict;
        len_a = '0;
        len_b = '0;
        dot = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            s = 80'($signed(item[i*COORD_WIDTH +: COORD_WIDTH]));
            p = 80'($signed(item[(NUM_AXES+i)*COORD_WIDTH +: COORD_WIDTH]));
            a = -s;
            b = p - s;
            len_a = len_a + a * a;
            len_b = len_b + b * b;
            dot = dot + a * b;
        end
        verdict.degenerate = (len_a == 0) || (len_b == 0);
        verdict.visible = 1'b0;
        if (!verdict.degenerate && dot >= 0)
        begin
            dot_u = 256'(dot);
            len_a_u = 256'(len_a);
            len_b_u = 256'(len_b);
            mask_u = 256'(mask);
            lhs = (dot_u * dot_u) << FRAC_BITS;
            rhs = len_a_u * len_b_u * mask_u;
            verdict.visible = (lhs >= rhs);
        end
        return verdict;
    endfunction

    // Idle stretch length: mostly short, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IN_TDATA_WIDTH-1:0] pack_coords(
        input logic signed [COORD_WIDTH-1:0] sx, sy, sz, px, py, pz
    );
        return {pz, py, px, sz, sy, sx};
    endfunction

    // Random request: mostly a satellite looking roughly earthwards with
    // varied spread, plus fully random words, tiny vectors, extremes and
    // degenerate geometry.
    function automatic logic [IN_TDATA_WIDTH-1:0] make_random_request();
        logic signed [COORD_WIDTH-1:0] s[3];
        logic signed [COORD_WIDTH-1:0] p[3];
        logic signed [COORD_WIDTH-1:0] b;
        int mode, sh;
        mode = $urandom_range(0, 99);
        sh = $urandom_range(0, 10);
        for (int i = 0; i < 3; i++)
        begin
            if (mode < 45)
            begin
                s[i] = $signed($urandom) >>> $urandom_range(0, 12);
                b = -(s[i] >>> sh) + ($signed($urandom) >>> $urandom_range(4, 31));
                p[i] = s[i] + b;
            end
            else if (mode < 65)
            begin
                s[i] = $urandom;
                p[i] = $urandom;
            end
            else if (mode < 82)
            begin
                s[i] = int'($urandom_range(0, 16)) - 8;
                p[i] = int'($urandom_range(0, 16)) - 8;
            end
            else if (mode < 92)
            begin
                case ($urandom_range(0, 4))
                    0: s[i] = C_MIN;
                    1: s[i] = C_MAX;
                    2: s[i] = 0;
                    3: s[i] = 1;
                    default: s[i] = -1;
                endcase
                case ($urandom_range(0, 4))
                    0: p[i] = C_MIN;
                    1: p[i] = C_MAX;
                    2: p[i] = 0;
                    3: p[i] = 1;
                    default: p[i] = -1;
                endcase
            end
            else
            begin
                s[i] = $urandom;
                p[i] = (sh < 5) ? s[i] : $urandom;
                if (sh >= 5)
                    s[i] = 0;
            end
        end
        return pack_coords(s[0], s[1], s[2], p[0], p[1], p[2]);
    endfunction

    task automatic push_request(input logic signed [COORD_WIDTH-1:0] sx, sy, sz, px, py, pz);
        coord_requests.insert(coord_requests.size(), pack_coords(sx, sy, sz, px, py, pz));
    endtask

    // Register write, made only while the pipeline is empty.
    task automatic write_mask(input logic [MASK_WIDTH-1:0] value);
        @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every request has been offered and answered, then let the
    // pipeline settle.
    task automatic drain_pipeline();
        int guard;
        guard = 0;
        while ((coord_requests.size() != 0 || s_tvalid || visibility_expected.size() != 0)
               && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (visibility_expected.size() != 0)
        begin
            $display("%0t: %0d expected verdicts never arrived", $time,
                     visibility_expected.size());
            mismatch_count++;
            visibility_expected.delete();
        end
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            coord_requests.insert(coord_requests.size(), make_random_request());
    endtask

    // Local copy of the threshold register.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_cos_sq_copy <= MASK_RESET;
        else if (cfg_valid && cfg_ready)
            mask_cos_sq_copy <= cfg_data;
    end

    // Request driver: predicts each accepted request, then offers the next
    // one after an optional gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                visibility_expected.insert(visibility_expected.size(),
                                           predict_visibility(s_tdata, mask_cos_sq_copy));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (coord_requests.size() != 0)
                begin
                    s_tdata <= coord_requests[0];
                    coord_requests.delete(0);
                    s_tvalid <= 1'b1;
                    send_gap <= (sender_gaps_on && $urandom_range(0, 99) < 45) ?
                                idle_length() : 0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_stall <= 0;
            hold_served <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (visibility_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, visible=%0b degenerate=%0b", $time,
                             m_tdata[OUT_VISIBLE_BIT], m_tdata[OUT_DEGENERATE_BIT]);
                    mismatch_count++;
                end
                else
                begin
                    oldest_verdict = visibility_expected[0];
                    visibility_expected.delete(0);
                    if (m_tdata[OUT_VISIBLE_BIT] !== oldest_verdict.visible)
                    begin
                        $display("%0t: visible mismatch, expected %0b, got %0b", $time,
                                 oldest_verdict.visible, m_tdata[OUT_VISIBLE_BIT]);
                        mismatch_count++;
                    end
                    if (m_tdata[OUT_DEGENERATE_BIT] !== oldest_verdict.degenerate)
                    begin
                        $display("%0t: degenerate mismatch, expected %0b, got %0b", $time,
                                 oldest_verdict.degenerate, m_tdata[OUT_DEGENERATE_BIT]);
                        mismatch_count++;
                    end
                end
            end

            if (hold_served != hold_requests)
            begin
                hold_served <= hold_requests;
                recv_stall <= LONG_HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                m_tready <= 1'b0;
            end
            else if (receiver_gaps_on && $urandom_range(0, 99) < 25)
            begin
                recv_stall <= idle_length() - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Run limit in case the block hangs.
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus phases, each under its own threshold setting.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset threshold of 70 degrees: degenerate geometry, extremes, and
        // points either side of the mask edge.
        push_request(0, 0, 0, 5, -7, 9);
        push_request(0, 0, 0, 0, 0, 0);
        push_request(123456, -98765, 4321, 123456, -98765, 4321);
        push_request(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        push_request(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        push_request(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
        push_request(C_MIN, 0, 0, 0, 0, 0);
        push_request(1000, 0, 0, 500, 0, 0);
        push_request(1000, 0, 0, 1000, 5, 0);
        push_request(1000, 0, 0, 2000, 3, 0);
        push_request(100000, 0, 0, 100000 - 342, 940, 0);
        push_request(100000, 0, 0, 100000 - 343, 939, 0);
        push_request(-1, -1, -1, C_MIN, C_MAX, C_MIN);
        push_request(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
        run_random(400);
        drain_pipeline();

        // Zero threshold: a right angle passes.
        write_mask(16'd0);
        sender_gaps_on = 1'b0;
        push_request(1000, 0, 0, 1000, 5, 0);
        push_request(1000, 0, 0, 2000, 3, 0);
        run_random(120);
        drain_pipeline();

        // Full-scale threshold: only near-aligned directions pass.
        write_mask(16'hFFFF);
        sender_gaps_on = 1'b1;
        push_request(1000, 0, 0, 0, 0, 0);
        push_request(1000000, 0, 0, 0, 2000, 0);
        push_request(1000000, 0, 0, 0, 5000, 0);
        run_random(120);
        drain_pipeline();

        // 45 degrees, exact equality on the edge, with the receiver holding off.
        write_mask(16'd32768);
        sender_gaps_on = 1'b0;
        hold_requests = hold_requests + 1;
        push_request(1, 0, 0, 0, 1, 0);
        push_request(2, 0, 0, 0, 3, 0);
        run_random(150);
        drain_pipeline();

        // Random threshold at full throughput.
        write_mask(MASK_WIDTH'($urandom_range(0, 65535)));
        receiver_gaps_on = 1'b0;
        run_random(200);
        drain_pipeline();

        // Smallest non-zero threshold.
        write_mask(16'd1);
        sender_gaps_on = 1'b1;
        receiver_gaps_on = 1'b1;
        run_random(100);
        drain_pipeline();

        // Another random threshold, sender gaps only.
        write_mask(MASK_WIDTH'($urandom_range(0, 65535)));
        receiver_gaps_on = 1'b0;
        run_random(160);
        drain_pipeline();

        // Back to 70 degrees, with a second long hold-off.
        write_mask(MASK_RESET);
        sender_gaps_on = 1'b0;
        receiver_gaps_on = 1'b1;
        hold_requests = hold_requests + 1;
        run_random(200);
        drain_pipeline();

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
design/snav_pkg.sv
design/snav_datapath.sv
design/satellite_nadir_angle_visibility.sv
tb/satellite_nadir_angle_visibility_tb.sv
